// ----- src/djb2_hashed_key_table_unit_macros.svh -----
// Assertion macros for the djb2 hashed key table unit.
// Used by the port checker; no other dependencies.
`ifndef DJB2_HASHED_KEY_TABLE_UNIT_MACROS_SVH
`define DJB2_HASHED_KEY_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define DJHKT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define DJHKT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/djhkt_pkg.sv -----
// Package for the djb2 hashed key table unit: sizes, codes and key functions.
// Has no dependencies; used by the top level and the port checker.
`timescale 1ns / 1ps

package djhkt_pkg;

    localparam int TABLE_SIZE     = 16;
    localparam int KEY_CHARS      = 8;
    localparam int KEY_W          = 64;
    localparam int FUNC_W         = 2;
    localparam int STATUS_W       = 2;
    localparam int BUCKET_FIELD_W = 4;
    localparam int COUNT_FIELD_W  = 5;
    localparam int BUCKET_W       = $clog2(TABLE_SIZE);
    localparam int COUNT_W        = $clog2(TABLE_SIZE + 1);
    localparam int HASH_START     = 5381;
    localparam int HASH_SHIFT     = 5;

    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [BUCKET_W-1:0] bucket_idx_t;
    typedef logic [COUNT_W-1:0]  count_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_QUERY  = 2'd2
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        RES_OK      = 2'd0,
        RES_TAKEN   = 2'd1,
        RES_MISSING = 2'd2
    } result_t;

    typedef enum logic [1:0] {
        ST_EMPTY    = 2'd0,
        ST_OCCUPIED = 2'd1,
        ST_DELETED  = 2'd2
    } bucket_state_t;

    // Clears every byte from the first zero byte on and every byte past KEY_CHARS.
    function automatic key_t normalize_key(input key_t raw);
        key_t out;
        logic done;
        out  = '0;
        done = 1'b0;
        for (int i = 0; i < KEY_CHARS; i++) begin
            if (raw[8*i +: 8] == 8'd0) begin
                done = 1'b1;
            end
            if (!done) begin
                out[8*i +: 8] = raw[8*i +: 8];
            end
        end
        return out;
    endfunction

    // Only the low bits of the hash select the bucket, so they are all that is kept.
    function automatic bucket_idx_t hash_bucket(input key_t key);
        bucket_idx_t h;
        logic done;
        h    = BUCKET_W'(HASH_START);
        done = 1'b0;
        for (int i = 0; i < KEY_CHARS; i++) begin
            if (key[8*i +: 8] == 8'd0) begin
                done = 1'b1;
            end
            if (!done) begin
                h = (h << HASH_SHIFT) + h + BUCKET_W'(key[8*i +: 8]);
            end
        end
        return h;
    endfunction

endpackage

// ----- src/djb2_hashed_key_table_unit.sv -----
// Top level of the djb2 hashed key table unit: bucket memories and request pipeline.
// Depends on djhkt_pkg.
`timescale 1ns / 1ps

// The unit takes one item per cycle as long as the result side keeps up, and returns
// each result in order through its output register. The first stage hashes the key and
// reads the bucket's key and status from the memories into registers; the second stage decides,
// writes the bucket back and loads the output register, forwarding its write to a
// following item that reads the same bucket. Bucket status is cleared at reset through
// one valid flag per bucket, so no clearing pass is needed and items are taken at once.
module djb2_hashed_key_table_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [djhkt_pkg::FUNC_W-1:0]         func,
    input  logic [djhkt_pkg::KEY_W-1:0]          id_key,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [djhkt_pkg::STATUS_W-1:0]       status,
    output logic [djhkt_pkg::BUCKET_FIELD_W-1:0] bucket,
    output logic [djhkt_pkg::COUNT_FIELD_W-1:0]  live_count
);
    import djhkt_pkg::*;

    key_t          key_mem [TABLE_SIZE];
    bucket_state_t state_mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] written_reg;

    logic          accept;
    logic          advance;
    logic          out_free;
    key_t          in_key;
    bucket_idx_t   in_bucket;

    logic          s1_valid_reg;
    func_t         s1_func_reg;
    key_t          s1_key_reg;
    bucket_idx_t   s1_bucket_reg;
    key_t          rd_key_reg;
    bucket_state_t rd_state_reg;

    count_t        count_reg;
    count_t        count_next;
    logic          key_we;
    logic          state_we;
    bucket_state_t wr_state;
    result_t       result;
    logic          match;

    logic          out_valid_reg;
    result_t       status_reg;
    bucket_idx_t   bucket_reg;
    count_t        live_count_reg;

    assign in_key    = normalize_key(id_key);
    assign in_bucket = hash_bucket(in_key);
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign accept    = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            written_reg   <= '0;
        end
        else
        begin
            s1_valid_reg <= accept || (s1_valid_reg && !advance);
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                count_reg     <= count_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_we)
            begin
                written_reg[s1_bucket_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg   <= func_t'(func);
            s1_key_reg    <= in_key;
            s1_bucket_reg <= in_bucket;
            if (key_we && s1_bucket_reg == in_bucket)
            begin
                rd_key_reg <= s1_key_reg;
            end
            else
            begin
                rd_key_reg <= key_mem[in_bucket];
            end
            if (state_we && s1_bucket_reg == in_bucket)
            begin
                rd_state_reg <= wr_state;
            end
            else if (written_reg[in_bucket])
            begin
                rd_state_reg <= state_mem[in_bucket];
            end
            else
            begin
                rd_state_reg <= ST_EMPTY;
            end
        end
        if (key_we)
        begin
            key_mem[s1_bucket_reg] <= s1_key_reg;
        end
        if (state_we)
        begin
            state_mem[s1_bucket_reg] <= wr_state;
        end
    end

    always_comb
    begin
        match      = (rd_state_reg == ST_OCCUPIED) && (rd_key_reg == s1_key_reg);
        count_next = count_reg;
        key_we     = 1'b0;
        state_we   = 1'b0;
        wr_state   = ST_OCCUPIED;
        result     = RES_MISSING;
        case (s1_func_reg)
            FUNC_INSERT:
            begin
                if (rd_state_reg == ST_OCCUPIED)
                begin
                    result = RES_TAKEN;
                end
                else
                begin
                    result     = RES_OK;
                    key_we     = advance;
                    state_we   = advance;
                    wr_state   = ST_OCCUPIED;
                    count_next = count_reg + 1'b1;
                end
            end
            FUNC_DELETE:
            begin
                if (match)
                begin
                    result     = RES_OK;
                    state_we   = advance;
                    wr_state   = ST_DELETED;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                result = match ? RES_OK : RES_MISSING;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg     <= result;
            bucket_reg     <= s1_bucket_reg;
            live_count_reg <= count_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = STATUS_W'(status_reg);
    assign bucket     = BUCKET_FIELD_W'(bucket_reg);
    assign live_count = COUNT_FIELD_W'(live_count_reg);

endmodule

// ----- src/djhkt_checker.sv -----
// Port checker for the djb2 hashed key table unit, bound to the top level.
// Depends on djhkt_pkg and djb2_hashed_key_table_unit_macros.svh.
`timescale 1ns / 1ps
`include "djb2_hashed_key_table_unit_macros.svh"

module djhkt_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic [djhkt_pkg::STATUS_W-1:0]       status,
    input logic [djhkt_pkg::BUCKET_FIELD_W-1:0] bucket,
    input logic [djhkt_pkg::COUNT_FIELD_W-1:0]  live_count
);
    import djhkt_pkg::*;

    logic                     seen_reg;
    logic [COUNT_FIELD_W-1:0] last_count_reg;
    logic                     out_accept;
    logic                     count_same;
    logic                     count_step;

    assign out_accept = out_valid && !out_stall;
    assign count_same = live_count == last_count_reg;
    assign count_step = count_same || (live_count == last_count_reg + 1'b1)
                        || (last_count_reg == live_count + 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= 1'b0;
            last_count_reg <= '0;
        end
        else if (out_accept)
        begin
            seen_reg       <= 1'b1;
            last_count_reg <= live_count;
        end
    end

    `DJHKT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(bucket) && $stable(live_count), "stalled item changed")
    `DJHKT_ASSERT_NOW(a_count_range, out_valid, live_count <= COUNT_FIELD_W'(TABLE_SIZE) && status != STATUS_W'(3), "result out of range")
    `DJHKT_ASSERT_NOW(a_count_step, out_valid && seen_reg, count_step, "live count jumped by more than one")
    `DJHKT_ASSERT_NOW(a_fail_keeps_count, out_valid && seen_reg && status != STATUS_W'(RES_OK), count_same, "failed request changed the count")

endmodule

bind djb2_hashed_key_table_unit djhkt_checker u_djhkt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .bucket     (bucket),
    .live_count (live_count)
);

// ----- sim/tb_djb2_hashed_key_table_unit.sv -----
// Self-checking testbench for djb2_hashed_key_table_unit: directed table, then random traffic.
// Predicts results of untyped items with its own copy of the bucket table; depends on djhkt_pkg.
`timescale 1ns / 1ps

module tb_djb2_hashed_key_table_unit;
    import djhkt_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
    localparam int RANDOM_ITEMS = 1100;
    localparam int KEY_POOL     = 24;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [BUCKET_FIELD_W-1:0] bucket;
        logic [COUNT_FIELD_W-1:0]  count;
    } outcome_t;

    typedef struct packed {
        logic [FUNC_W-1:0] op;
        key_t              key;
        logic              typed;
        outcome_t          want;
    } table_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [FUNC_W-1:0]         func = '0;
    logic [KEY_W-1:0]          id_key = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [STATUS_W-1:0]       status;
    logic [BUCKET_FIELD_W-1:0] bucket;
    logic [COUNT_FIELD_W-1:0]  live_count;

    bucket_state_t slot_state [TABLE_SIZE];
    key_t          slot_key [TABLE_SIZE];
    int            live_keys;

    outcome_t   pending_q [$];
    table_row_t directed_rows [$];
    key_t       pool_key [KEY_POOL];
    int         pool_len [KEY_POOL];

    int  errors = 0;
    int  accepted = 0;
    int  n_ok = 0;
    int  n_taken = 0;
    int  n_missing = 0;
    int  peak_live = 0;
    int  input_held = 0;
    int  cycles = 0;
    int  hold_left = 0;
    int  stall_roll;
    bit  calm = 1'b0;
    bit  hold_request = 1'b0;

    djb2_hashed_key_table_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .id_key     (id_key),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .bucket     (bucket),
        .live_count (live_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic key_t trim_key(input key_t raw);
        key_t k;
        k = '0;
        for (int i = 0; i < KEY_CHARS; i++)
        begin
            if (raw[8*i +: 8] == 8'd0)
                break;
            k[8*i +: 8] = raw[8*i +: 8];
        end
        return k;
    endfunction

    function automatic logic [BUCKET_FIELD_W-1:0] djb2_slot(input key_t k);
        logic [31:0] h;
        h = HASH_START;
        for (int i = 0; i < KEY_CHARS; i++)
        begin
            if (k[8*i +: 8] == 8'd0)
                break;
            h = (h << HASH_SHIFT) + h + {24'd0, k[8*i +: 8]};
        end
        return BUCKET_FIELD_W'(h % TABLE_SIZE);
    endfunction

    function automatic outcome_t apply_request(input logic [FUNC_W-1:0] op, input key_t raw);
        key_t                      k;
        logic [BUCKET_FIELD_W-1:0] b;
        logic                      hit;
        outcome_t                  o;
        k   = trim_key(raw);
        b   = djb2_slot(k);
        hit = (slot_state[b] == ST_OCCUPIED) && (slot_key[b] == k);
        case (op)
            FUNC_INSERT:
            begin
                if (slot_state[b] == ST_OCCUPIED)
                    o.status = RES_TAKEN;
                else
                begin
                    slot_key[b]   = k;
                    slot_state[b] = ST_OCCUPIED;
                    live_keys++;
                    o.status = RES_OK;
                end
            end
            FUNC_DELETE:
            begin
                if (hit)
                begin
                    slot_state[b] = ST_DELETED;
                    live_keys--;
                    o.status = RES_OK;
                end
                else
                    o.status = RES_MISSING;
            end
            default:
                o.status = hit ? RES_OK : RES_MISSING;
        endcase
        o.bucket = b;
        o.count  = COUNT_FIELD_W'(live_keys);
        if (live_keys > peak_live)
            peak_live = live_keys;
        return o;
    endfunction

    task automatic add_row(input logic [FUNC_W-1:0] op, input key_t k, input logic typed,
                           input logic [STATUS_W-1:0] st, input int bk, input int cnt);
        table_row_t row;
        row.op   = op;
        row.key  = k;
        row.typed = typed;
        row.want = '{status: st, bucket: BUCKET_FIELD_W'(bk), count: COUNT_FIELD_W'(cnt)};
        directed_rows.push_back(row);
    endtask

    task automatic idle_gap();
        int roll;
        int n;
        roll = $urandom_range(0, 99);
        if (calm || roll < 65)
            n = 0;
        else if (roll < 95)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(8, 40);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic offer(input logic [FUNC_W-1:0] op, input key_t k, input logic typed,
                         input outcome_t want);
        outcome_t o;
        in_valid <= 1'b1;
        func     <= op;
        id_key   <= k;
        do
            @(posedge clk);
        while (in_stall);
        o = apply_request(op, k);
        pending_q.push_back(typed ? want : o);
        accepted++;
    endtask

    initial
    begin
        int       roll;
        int       idx;
        int       len;
        key_t     k;
        logic [FUNC_W-1:0] op;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            slot_state[i] = ST_EMPTY;
            slot_key[i]   = '0;
        end
        live_keys = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(FUNC_QUERY,  64'h0,                   1, RES_MISSING, 5, 0);
        add_row(FUNC_DELETE, 64'h61,                  1, RES_MISSING, 6, 0);
        add_row(FUNC_INSERT, 64'h61,                  1, RES_OK,      6, 1);
        add_row(FUNC_INSERT, 64'h61,                  1, RES_TAKEN,   6, 1);
        add_row(FUNC_INSERT, 64'h71,                  1, RES_TAKEN,   6, 1);
        add_row(FUNC_QUERY,  64'h61,                  1, RES_OK,      6, 1);
        add_row(FUNC_QUERY,  64'h71,                  1, RES_MISSING, 6, 1);
        add_row(FUNC_DELETE, 64'h71,                  1, RES_MISSING, 6, 1);
        add_row(FUNC_DELETE, 64'h61,                  1, RES_OK,      6, 0);
        add_row(FUNC_DELETE, 64'h61,                  1, RES_MISSING, 6, 0);
        add_row(FUNC_QUERY,  64'h61,                  1, RES_MISSING, 6, 0);
        add_row(FUNC_INSERT, 64'h71,                  1, RES_OK,      6, 1);
        add_row(FUNC_SPARE,  64'h71,                  1, RES_OK,      6, 1);
        add_row(FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 1, RES_OK,      13, 2);
        add_row(FUNC_QUERY,  64'hFFFF_FFFF_FF00_0071, 1, RES_OK,      6, 2);
        add_row(FUNC_INSERT, 64'h0,                   1, RES_OK,      5, 3);
        add_row(FUNC_QUERY,  64'hAB00_0000_0000_0000, 1, RES_OK,      5, 3);
        add_row(FUNC_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 1, RES_OK,      13, 2);
        add_row(FUNC_INSERT, 64'h0102_0304_0506_0708, 1, RES_OK,      9, 3);
        add_row(FUNC_INSERT, 64'h8080_8080_8080_8080, 1, RES_TAKEN,   5, 3);
        add_row(FUNC_SPARE,  64'h0102_0304_0506_0708, 1, RES_OK,      9, 3);
        add_row(FUNC_INSERT, 64'h7F7E_7D7C_7B7A_7978, 0, RES_OK,      0, 0);
        add_row(FUNC_DELETE, 64'h6261,                0, RES_OK,      0, 0);
        add_row(FUNC_QUERY,  64'hFFFF_FFFF_FFFF_FF00, 0, RES_OK,      0, 0);

        foreach (directed_rows[i])
        begin
            idle_gap();
            offer(directed_rows[i].op, directed_rows[i].key, directed_rows[i].typed,
                  directed_rows[i].want);
        end

        for (int p = 0; p < KEY_POOL; p++)
        begin
            pool_len[p] = $urandom_range(0, 8);
            pool_key[p] = '0;
            for (int j = 0; j < pool_len[p]; j++)
                pool_key[p][8*j +: 8] = 8'($urandom_range(1, 255));
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 300)
                hold_request = 1'b1;
            calm = (n >= 600 && n < 800);
            roll = $urandom_range(0, 99);
            if (roll < 40)
                op = FUNC_INSERT;
            else if (roll < 65)
                op = FUNC_DELETE;
            else if (roll < 95)
                op = FUNC_QUERY;
            else
                op = FUNC_SPARE;
            if ($urandom_range(0, 9) == 0)
                k = {$urandom, $urandom};
            else
            begin
                idx = $urandom_range(0, KEY_POOL - 1);
                k   = pool_key[idx];
                len = pool_len[idx];
                if (len < 7 && $urandom_range(0, 1) == 1)
                    for (int j = len + 1; j < 8; j++)
                        k[8*j +: 8] = 8'($urandom_range(0, 255));
            end
            idle_gap();
            offer(op, k, 1'b0, '0);
        end
        in_valid <= 1'b0;
        calm = 1'b0;

        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Covered %0d items: %0d done, %0d taken, %0d not found; peak occupancy %0d.",
                 accepted, n_ok, n_taken, n_missing, peak_live);
        $display("Input was held off for %0d cycles while items were waiting.", input_held);
        if (errors == 0)
            $display("tb_djb2_hashed_key_table_unit passed");
        else
            $display("tb_djb2_hashed_key_table_unit failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_stall)
            input_held++;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_q.size() == 0)
            begin
                $display("%0t: result with nothing expected: status %0d bucket %0d count %0d",
                         $realtime, status, bucket, live_count);
                errors++;
            end
            else
            begin
                if (status != pending_q[0].status)
                begin
                    $display("%0t: status expected %0d got %0d",
                             $realtime, pending_q[0].status, status);
                    errors++;
                end
                if (bucket != pending_q[0].bucket)
                begin
                    $display("%0t: bucket expected %0d got %0d",
                             $realtime, pending_q[0].bucket, bucket);
                    errors++;
                end
                if (live_count != pending_q[0].count)
                begin
                    $display("%0t: live_count expected %0d got %0d",
                             $realtime, pending_q[0].count, live_count);
                    errors++;
                end
                case (status)
                    RES_OK:    n_ok++;
                    RES_TAKEN: n_taken++;
                    default:   n_missing++;
                endcase
                void'(pending_q.pop_front());
            end
        end

        stall_roll = $urandom_range(0, 99);
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = 80;
            out_stall   <= 1'b1;
        end
        else if (calm || !rst_n || stall_roll < 70)
            out_stall <= 1'b0;
        else if (stall_roll < 97)
            out_stall <= 1'b1;
        else
        begin
            hold_left  = $urandom_range(5, 20);
            out_stall <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycles, pending_q.size());
            $display("tb_djb2_hashed_key_table_unit failed");
            $finish;
        end
    end

endmodule

// ----- files.f -----
+incdir+src
src/djhkt_pkg.sv
src/djb2_hashed_key_table_unit.sv
src/djhkt_checker.sv
sim/tb_djb2_hashed_key_table_unit.sv
